// File: sv/hil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hil_pkg
// Shared types, codes and constants of the hex image loader.
// ----------------------------------------------------------------------------
package hil_pkg;

  localparam logic [31:0] WINDOW_BASE_RST  = 32'h0000_0800;
  localparam logic [31:0] WINDOW_LIMIT_RST = 32'h0000_0e00;
  localparam logic [3:0]  DIGITS_PER_WORD  = 4'd8;
  localparam logic [1:0]  ALIGN_MASK       = 2'b11;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic REG_WINDOW_BASE  = 1'b0;
  localparam logic REG_WINDOW_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_GO    = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    K_RANGE_ERR  = 3'd0,
    K_STARTED    = 3'd1,
    K_WRITE      = 3'd2,
    K_DATA_ERR   = 3'd3,
    K_SUM_ERR    = 3'd4,
    K_LOAD_OK    = 3'd5,
    K_GO_OK      = 3'd6,
    K_GO_REFUSED = 3'd7
  } kind_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] target_address;
    logic [31:0] word_count;
    logic [31:0] announced_sum;
    logic [7:0]  rx_char;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [31:0] running_sum;
    logic [31:0] loaded_words;
    logic        last;
  } result_t;

  // Up to two results leave the core for one item.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  // Hex digit decode, either case. Bit 4 flags a valid digit.
  function automatic logic [4:0] decode_hex(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      d = {1'b1, c[3:0] + 4'd9};
    return d;
  endfunction

endpackage

// File: sv/hil_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hil_core
// Loader state, window registers and per-word result generation.
// ----------------------------------------------------------------------------
module hil_core
  import hil_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        item_valid,
  input  item_t       item,
  output push_t       push
);

  logic [31:0] window_base_r, window_limit_r;
  logic        loading_r, loading_nxt;
  logic [3:0]  digit_count_r, digit_count_nxt;
  logic [31:0] word_accum_r, word_accum_nxt;
  logic [31:0] next_address_r, next_address_nxt;
  logic [31:0] words_left_r, words_left_nxt;
  logic [31:0] sum_accum_r, sum_accum_nxt;
  logic [31:0] sum_target_r, sum_target_nxt;
  logic [31:0] image_base_r, image_base_nxt;
  logic [31:0] image_length_r, image_length_nxt;
  logic        image_ok_r, image_ok_nxt;

  logic [31:0] span;
  logic        range_bad;
  logic [4:0]  dig;
  logic [31:0] acc_new;
  logic [3:0]  cnt_new;
  logic [31:0] sum_new;
  logic        is_space;
  result_t     blank;

  assign span = (window_limit_r - item.target_address) >> 2;
  assign range_bad = ((item.target_address[1:0] & ALIGN_MASK) != 2'b00)
                  || (item.target_address < window_base_r)
                  || (item.target_address >= window_limit_r)
                  || (item.word_count == 32'd0)
                  || (item.word_count > span);
  assign dig      = decode_hex(item.rx_char);
  assign acc_new  = {word_accum_r[27:0], dig[3:0]};
  assign cnt_new  = digit_count_r + 4'd1;
  assign sum_new  = sum_accum_r + acc_new;
  assign is_space = (item.rx_char == CH_SPACE) || (item.rx_char == CH_TAB)
                 || (item.rx_char == CH_CR) || (item.rx_char == CH_LF);

  always_comb begin
    blank = '{kind: K_RANGE_ERR, write_address: 32'd0, write_data: 32'd0,
              running_sum: 32'd0, loaded_words: 32'd0, last: 1'b1};
    loading_nxt      = loading_r;
    digit_count_nxt  = digit_count_r;
    word_accum_nxt   = word_accum_r;
    next_address_nxt = next_address_r;
    words_left_nxt   = words_left_r;
    sum_accum_nxt    = sum_accum_r;
    sum_target_nxt   = sum_target_r;
    image_base_nxt   = image_base_r;
    image_length_nxt = image_length_r;
    image_ok_nxt     = image_ok_r;
    push.count = 2'd0;
    push.res0  = blank;
    push.res1  = blank;
    if (item_valid) begin
      unique case (item.func)
        FUNC_START: begin
          image_ok_nxt = 1'b0;
          loading_nxt  = 1'b0;
          push.count   = 2'd1;
          if (!range_bad) begin
            loading_nxt      = 1'b1;
            digit_count_nxt  = 4'd0;
            word_accum_nxt   = 32'd0;
            next_address_nxt = item.target_address;
            words_left_nxt   = item.word_count;
            sum_accum_nxt    = 32'd0;
            sum_target_nxt   = item.announced_sum;
            image_base_nxt   = item.target_address;
            image_length_nxt = item.word_count;
            push.res0.kind   = K_STARTED;
          end
        end
        FUNC_CHAR: begin
          if (loading_r) begin
            if (dig[4]) begin
              if (cnt_new != DIGITS_PER_WORD) begin
                word_accum_nxt  = acc_new;
                digit_count_nxt = cnt_new;
              end else begin
                digit_count_nxt  = 4'd0;
                word_accum_nxt   = 32'd0;
                sum_accum_nxt    = sum_new;
                next_address_nxt = next_address_r + 32'd4;
                words_left_nxt   = words_left_r - 32'd1;
                push.res0.kind          = K_WRITE;
                push.res0.write_address = next_address_r;
                push.res0.write_data    = acc_new;
                if (words_left_r != 32'd1) begin
                  push.count = 2'd1;
                end else begin
                  // Final word: the write is followed by the sum verdict.
                  push.count          = 2'd2;
                  push.res0.last      = 1'b0;
                  loading_nxt         = 1'b0;
                  push.res1.running_sum = sum_new;
                  if (sum_new != sum_target_r) begin
                    push.res1.kind = K_SUM_ERR;
                  end else begin
                    image_ok_nxt           = 1'b1;
                    push.res1.kind         = K_LOAD_OK;
                    push.res1.loaded_words = image_length_r;
                  end
                end
              end
            end else if (!(is_space && digit_count_r == 4'd0)) begin
              loading_nxt     = 1'b0;
              digit_count_nxt = 4'd0;
              word_accum_nxt  = 32'd0;
              push.count      = 2'd1;
              push.res0.kind  = K_DATA_ERR;
            end
          end
        end
        FUNC_GO: begin
          push.count = 2'd1;
          if (image_ok_r && item.target_address == image_base_r
              && (item.target_address[1:0] & ALIGN_MASK) == 2'b00
              && image_length_r != 32'd0) begin
            push.res0.kind          = K_GO_OK;
            push.res0.write_address = item.target_address;
          end else begin
            push.res0.kind = K_GO_REFUSED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r  <= WINDOW_BASE_RST;
      window_limit_r <= WINDOW_LIMIT_RST;
      loading_r      <= 1'b0;
      digit_count_r  <= 4'd0;
      word_accum_r   <= 32'd0;
      next_address_r <= 32'd0;
      words_left_r   <= 32'd0;
      sum_accum_r    <= 32'd0;
      sum_target_r   <= 32'd0;
      image_base_r   <= 32'd0;
      image_length_r <= 32'd0;
      image_ok_r     <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_WINDOW_BASE)  window_base_r  <= cfg_wdata;
      if (cfg_we && cfg_index == REG_WINDOW_LIMIT) window_limit_r <= cfg_wdata;
      loading_r      <= loading_nxt;
      digit_count_r  <= digit_count_nxt;
      word_accum_r   <= word_accum_nxt;
      next_address_r <= next_address_nxt;
      words_left_r   <= words_left_nxt;
      sum_accum_r    <= sum_accum_nxt;
      sum_target_r   <= sum_target_nxt;
      image_base_r   <= image_base_nxt;
      image_length_r <= image_length_nxt;
      image_ok_r     <= image_ok_nxt;
    end
  end

endmodule

// File: sv/hil_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hil_fifo
// Result queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module hil_fifo
  import hil_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  input  logic             pop,
  output result_t          head,
  output logic             head_valid,
  output logic [FIFO_AW:0] count
);

  result_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wptr_r, rptr_r;
  logic [FIFO_AW:0]    count_r, count_nxt;

  assign head       = mem[rptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;
  assign count_nxt  = count_r + {{(FIFO_AW-1){1'b0}}, push.count}
                    - {{FIFO_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wptr_r] <= push.res0;
    if (push.count == 2'd2) mem[wptr_r + FIFO_AW'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + FIFO_AW'(push.count);
      rptr_r  <= rptr_r + FIFO_AW'(pop);
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/hex_image_loader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_image_loader
// Serial hex image loader with window check, checksum and go permission.
// ----------------------------------------------------------------------------
// Timing: a word is registered at acceptance, processed in the next cycle; its
//   results reach the output after earlier queued ones. Throughput: one input
//   word per cycle while in_tready is high; the queue drains one result per
//   cycle while out_tready is high; a final image word takes two output slots.
// Reset: synchronous, active low; loader state clears, the window returns to
//   0x800..0xE00 and the result queue empties.
// ----------------------------------------------------------------------------
module hex_image_loader
  import hil_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: target_address[31:0], word_count[63:32], announced_sum[95:64],
  //        rx_char[103:96]
  input  logic [103:0] in_tdata,
  // tuser: func[1:0]
  input  logic [1:0]   in_tuser,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: write_address[31:0], write_data[63:32], running_sum[95:64],
  //        loaded_words[127:96]
  output logic [127:0] out_tdata,
  // tuser: kind[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  // Input register: one word waits here for the core.
  logic             pend_r;
  item_t            item_r;
  push_t            push;
  result_t          head;
  logic             head_valid;
  logic [FIFO_AW:0] fifo_count;
  logic [FIFO_AW:0] reserved;

  // A pending word may produce two results, so it reserves two queue slots.
  // The check uses registered counts only, keeping ready off the data path.
  assign reserved  = fifo_count + {{(FIFO_AW-1){1'b0}}, pend_r, 1'b0};
  assign in_tready = (reserved <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func           <= func_t'(in_tuser);
      item_r.target_address <= in_tdata[31:0];
      item_r.word_count     <= in_tdata[63:32];
      item_r.announced_sum  <= in_tdata[95:64];
      item_r.rx_char        <= in_tdata[103:96];
    end
  end

  hil_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (pend_r),
    .item       (item_r),
    .push       (push)
  );

  hil_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (head_valid && out_tready),
    .head       (head),
    .head_valid (head_valid),
    .count      (fifo_count)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = {head.loaded_words, head.running_sum,
                       head.write_data, head.write_address};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule
